// File: rtl/gdc_pkg.sv
package gdc_pkg;

    localparam int MaxInCh  = 64;
    localparam int MaxOutCh = 64;
    localparam int MaxSeq   = 1024;
    localparam int MaxTaps  = 16;

    localparam int WDepth = MaxOutCh * MaxInCh * MaxTaps;
    localparam int WAw    = $clog2(WDepth);
    localparam int ChAw   = $clog2(MaxInCh);
    localparam int OchAw  = $clog2(MaxOutCh);
    localparam int SeqAw  = $clog2(MaxSeq);
    localparam int SDepth = MaxInCh * MaxSeq;
    localparam int SAw    = ChAw + SeqAw;

    localparam int DivW = 7;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    localparam logic [3:0] CFG_TAPS    = 4'd0;
    localparam logic [3:0] CFG_STEP    = 4'd1;
    localparam logic [3:0] CFG_PAD     = 4'd2;
    localparam logic [3:0] CFG_SPREAD  = 4'd3;
    localparam logic [3:0] CFG_GROUPS  = 4'd4;
    localparam logic [3:0] CFG_IN_CH   = 4'd5;
    localparam logic [3:0] CFG_OUT_CH  = 4'd6;
    localparam logic [3:0] CFG_SEQ_LEN = 4'd7;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        weight_addr;
        logic [5:0]         chan;
        logic [9:0]         pos;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] result;
        logic [5:0]         out_chan;
        logic [9:0]         out_pos;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic init;
        logic valid;
    } t_mac_ctl;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/grouped_dilated_conv1d.sv
// Grouped, strided, zero-padded, dilated 1-D convolution with on-chip weight,
// bias and sample stores. Every beat first makes three passes through one
// shared serial divider (input and output channels per group, then the
// group of the named channel), and a new beat is accepted only once the
// previous one is finished. A compute beat runs setup, then one
// multiply-accumulate per tap for each input channel of the group through a
// single shared MAC fed from the two single-port-read stores, then a pipeline
// drain. A result beat waits only while the output register
// still holds an unaccepted result; once it is registered, the next input beat
// can be taken.
module grouped_dilated_conv1d (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gdc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gdc_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data
);
    import gdc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV_IN  = 4'd1;
    localparam logic [3:0] S_DIV_OUT = 4'd2;
    localparam logic [3:0] S_PREP    = 4'd3;
    localparam logic [3:0] S_DIV_GRP = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_RUN     = 4'd6;
    localparam logic [3:0] S_DRAIN   = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    logic [4:0]  r_taps, r_step, r_spread;
    logic [3:0]  r_pad;
    logic [6:0]  r_groups, r_in_ch, r_out_ch;
    logic [10:0] r_seq_len;

    logic [3:0]  r_state, n_state;
    t_in_item    r_item;
    logic [6:0]  r_icpg, r_ocpg, r_grp;
    logic        r_in_div_ok, r_out_div_ok;
    logic [13:0] r_wtot_a;
    logic [18:0] r_wtot;
    logic [12:0] r_wbase_a;
    logic [17:0] r_wbase;
    logic [14:0] r_ps;
    logic [9:0]  r_span;
    logic [11:0] r_padded;
    logic signed [16:0] r_ip, r_ip0;
    logic [ChAw-1:0] r_ic;
    logic [WAw-1:0]  r_widx;
    logic [6:0]  r_icg;
    logic [4:0]  r_k;
    logic [1:0]  r_drain;
    logic        r_err;
    logic        r_tag1;

    logic [31:0] r_bias_mem [MaxOutCh];
    logic [MaxOutCh-1:0] r_bias_vld;
    logic signed [31:0] r_bias_rd;
    logic        r_bias_rv;

    logic        r_out_vld;
    t_out_item   r_out;

    logic            in_fire;
    logic            div_start, div_done;
    logic [DivW-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic            cfg_ok, cmd_ok, tap_ok, last_tap, last_icg;
    logic            w_we, s_we;
    logic [15:0]     w_rdata, s_rdata;
    logic [SAw-1:0]  s_waddr, s_raddr;
    logic signed [15:0] wr_value;
    t_mac_ctl        mac_ctl;
    logic signed [47:0] acc;
    logic            emit_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps    <= 5'd3;
            r_step    <= 5'd1;
            r_pad     <= 4'd0;
            r_spread  <= 5'd1;
            r_groups  <= 7'd1;
            r_in_ch   <= 7'd1;
            r_out_ch  <= 7'd1;
            r_seq_len <= 11'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAPS:    r_taps    <= i_cfg_data[4:0];
                CFG_STEP:    r_step    <= i_cfg_data[4:0];
                CFG_PAD:     r_pad     <= i_cfg_data[3:0];
                CFG_SPREAD:  r_spread  <= i_cfg_data[4:0];
                CFG_GROUPS:  r_groups  <= i_cfg_data[6:0];
                CFG_IN_CH:   r_in_ch   <= i_cfg_data[6:0];
                CFG_OUT_CH:  r_out_ch  <= i_cfg_data[6:0];
                CFG_SEQ_LEN: r_seq_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {1'b0, r_item.chan};
        div_divisor  = r_ocpg;
        unique case (r_state)
            S_IDLE: begin
                div_start    = in_fire;
                div_dividend = r_in_ch;
                div_divisor  = r_groups;
            end
            S_DIV_IN: begin
                div_start    = div_done;
                div_dividend = r_out_ch;
                div_divisor  = r_groups;
            end
            S_PREP: div_start = 1'b1;
            default: ;
        endcase
    end

    gdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign cfg_ok = (r_taps != 5'd0) && (32'(r_taps) <= 32'(MaxTaps))
        && (r_step != 5'd0) && (r_spread != 5'd0) && (r_groups != 7'd0)
        && (r_in_ch != 7'd0) && (32'(r_in_ch) <= 32'(MaxInCh))
        && (r_out_ch != 7'd0) && (32'(r_out_ch) <= 32'(MaxOutCh))
        && (r_seq_len != 11'd0) && (32'(r_seq_len) <= 32'(MaxSeq))
        && r_in_div_ok && r_out_div_ok;

    always_comb begin
        unique case (r_item.command)
            CMD_WEIGHT:  cmd_ok = 32'(r_item.weight_addr) < 32'(r_wtot)
                                  && 32'(r_item.weight_addr) < 32'(WDepth);
            CMD_BIAS:    cmd_ok = 7'(r_item.chan) < r_out_ch
                                  && 32'(r_item.chan) < 32'(MaxOutCh);
            CMD_SAMPLE:  cmd_ok = 7'(r_item.chan) < r_in_ch
                                  && 11'(r_item.pos) < r_seq_len;
            CMD_COMPUTE: cmd_ok = 7'(r_item.chan) < r_out_ch
                                  && 12'(r_span) <= r_padded
                                  && 16'(r_ps) + 16'(r_span) <= 16'(r_padded);
            default:     cmd_ok = 1'b0;
        endcase
    end

    assign tap_ok   = !r_ip[16] && (r_ip[15:0] < 16'(r_seq_len));
    assign last_tap = (r_k == r_taps - 5'd1);
    assign last_icg = (r_icg == r_icpg - 7'd1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_fire) n_state = S_DIV_IN;
            S_DIV_IN:  if (div_done) n_state = S_DIV_OUT;
            S_DIV_OUT: if (div_done) n_state = S_PREP;
            S_PREP:    n_state = S_DIV_GRP;
            S_DIV_GRP: if (div_done) n_state = S_CHECK;
            S_CHECK: begin
                if (!(cfg_ok && cmd_ok)) begin
                    n_state = S_EMIT;
                end else if (r_item.command == CMD_COMPUTE) begin
                    n_state = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN:     if (last_tap && last_icg) n_state = S_DRAIN;
            S_DRAIN:   if (r_drain == 2'd0) n_state = S_EMIT;
            S_EMIT:    if (emit_fire) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tag1  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag1  <= (r_state == S_RUN) && tap_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        unique case (r_state)
            S_DIV_IN: if (div_done) begin
                r_icpg      <= div_quo;
                r_in_div_ok <= (div_rem == '0);
            end
            S_DIV_OUT: if (div_done) begin
                r_ocpg       <= div_quo;
                r_out_div_ok <= (div_rem == '0);
            end
            S_PREP: begin
                r_wtot_a  <= r_out_ch * r_icpg;
                r_wbase_a <= r_item.chan * r_icpg;
                r_ps      <= r_item.pos * r_step;
                r_span    <= 10'(r_spread) * (10'(r_taps) - 10'd1) + 10'd1;
                r_padded  <= 12'(r_seq_len) + {7'd0, r_pad, 1'b0};
            end
            S_DIV_GRP: begin
                r_wtot  <= r_wtot_a * r_taps;
                r_wbase <= r_wbase_a * r_taps;
                if (div_done) begin
                    r_grp <= div_quo;
                end
            end
            S_CHECK: begin
                r_ic   <= ChAw'(r_grp * r_icpg);
                r_ip   <= $signed({2'b00, r_ps}) - $signed({13'd0, r_pad});
                r_ip0  <= $signed({2'b00, r_ps}) - $signed({13'd0, r_pad});
                r_widx <= WAw'(r_wbase);
                r_icg  <= '0;
                r_k    <= '0;
                r_err  <= !(cfg_ok && cmd_ok);
                r_drain <= 2'd2;
            end
            S_RUN: begin
                r_widx <= r_widx + 1'b1;
                if (last_tap) begin
                    r_k   <= '0;
                    r_ip  <= r_ip0;
                    r_icg <= r_icg + 7'd1;
                    r_ic  <= r_ic + 1'b1;
                end else begin
                    r_k  <= r_k + 5'd1;
                    r_ip <= r_ip + $signed({12'd0, r_spread});
                end
            end
            S_DRAIN: r_drain <= r_drain - 2'd1;
            default: ;
        endcase
    end

    // bias store, cleared by valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_vld <= '0;
        end else if (r_state == S_CHECK && cfg_ok && cmd_ok
                     && r_item.command == CMD_BIAS) begin
            r_bias_vld[OchAw'(r_item.chan)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK && cfg_ok && cmd_ok && r_item.command == CMD_BIAS) begin
            r_bias_mem[OchAw'(r_item.chan)] <= r_item.value;
        end
        r_bias_rd <= r_bias_mem[OchAw'(r_item.chan)];
        r_bias_rv <= r_bias_vld[OchAw'(r_item.chan)];
    end

    assign wr_value = sat16(r_item.value);
    assign w_we = (r_state == S_CHECK) && cfg_ok && cmd_ok && (r_item.command == CMD_WEIGHT);
    assign s_we = (r_state == S_CHECK) && cfg_ok && cmd_ok && (r_item.command == CMD_SAMPLE);
    assign s_waddr = {ChAw'(r_item.chan), SeqAw'(r_item.pos)};
    assign s_raddr = {r_ic, r_ip[SeqAw-1:0]};

    gdc_ram #(.Width(16), .Depth(WDepth)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (WAw'(r_item.weight_addr)),
        .i_wdata (wr_value),
        .i_raddr (r_widx),
        .o_rdata (w_rdata)
    );

    gdc_ram #(.Width(16), .Depth(SDepth)) u_sram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (wr_value),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign mac_ctl.init  = (r_state == S_CHECK);
    assign mac_ctl.valid = r_tag1;

    gdc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_init_val (r_bias_rv ? r_bias_rd : 32'sd0),
        .i_a        ($signed(s_rdata)),
        .i_b        ($signed(w_rdata)),
        .o_acc      (acc)
    );

    // output register
    assign emit_fire = (r_state == S_EMIT) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out.result   <= r_err ? 48'sd0 : acc;
            r_out.out_chan <= r_item.chan;
            r_out.out_pos  <= r_item.pos;
            r_out.status   <= r_err;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_run_icg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_icg < r_icpg)
        else $error("group input counter past its end");

    a_run_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_k < r_taps)
        else $error("tap counter past its end");

    a_tag_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag1 |-> $past(r_state) == S_RUN)
        else $error("mac beat outside the run phase");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_DRAIN) |-> !w_we && !s_we && !in_fire)
        else $error("store write or input beat during compute");

endmodule

// File: rtl/gdc_ram.sv
module gdc_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gdc_div.sv
module gdc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [gdc_pkg::DivW-1:0] i_dividend,
    input  logic [gdc_pkg::DivW-1:0] i_divisor,
    output logic                   o_done,
    output logic [gdc_pkg::DivW-1:0] o_quo,
    output logic [gdc_pkg::DivW-1:0] o_rem
);
    import gdc_pkg::*;

    localparam int CntW = $clog2(DivW + 1);

    logic [DivW-1:0] r_quo;
    logic [DivW-1:0] r_rem;
    logic [DivW-1:0] r_dsr;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DivW:0]   shifted;
    logic [DivW:0]   trial;

    assign shifted = {r_rem, r_quo[DivW-1]};
    assign trial   = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DivW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DivW]) begin
                r_rem <= trial[DivW-1:0];
                r_quo <= {r_quo[DivW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DivW-1:0];
                r_quo <= {r_quo[DivW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/gdc_mac.sv
module gdc_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdc_pkg::t_mac_ctl   i_ctl,
    input  logic signed [31:0]  i_init_val,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    output logic signed [47:0]  o_acc
);
    import gdc_pkg::*;

    logic signed [31:0] r_prod;
    logic               r_pvld;
    logic signed [47:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.init) begin
            r_acc <= 48'(i_init_val);
        end else if (r_pvld) begin
            r_acc <= r_acc + 48'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
